// File: hdl/aps_pkg.sv
// Shared types, constants and codes for the positional array store.
package aps_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam int unsigned CMD_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NEW_COUNT_W = 5;
  localparam int unsigned FOUND_W = 5;
  // Wide enough to compare a position against the count plus one.
  localparam int unsigned CMP_W = POS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_SEARCH   = 2'd2,
    CMD_TRAVERSE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TRAV
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the incoming request
    logic exec;   // produce the single result and update the store
    logic emit;   // produce one traverse result and advance the index
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_trav;
    logic count_zero;
    logic trav_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/aps_if.sv
// Request and result channel interfaces of the positional array store.
interface aps_cmd_if;
  import aps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface aps_res_if;
  import aps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [NEW_COUNT_W-1:0]   new_count;
  logic [FOUND_W-1:0]       found_position;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, status, new_count, found_position, element, last,
                  input ready);
  modport sink (input valid, status, new_count, found_position, element, last,
                output ready);
endinterface

// File: hdl/aps_ctrl.sv
// Sequencing state machine of the positional array store.
module aps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output aps_pkg::ctrl_cmd_t cmd_o,
  input  aps_pkg::dp_stat_t  stat_i
);
  import aps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.is_trav && !stat_i.count_zero) begin
          state_d = S_TRAV;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_TRAV: begin
        if (stat_i.out_free && stat_i.trav_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = stat_i.out_free && !(stat_i.is_trav && !stat_i.count_zero);
      end
      S_TRAV: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/aps_datapath.sv
// Entry cells, count, search logic and result register of the positional array store.
module aps_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aps_pkg::ctrl_cmd_t                cmd_i,
  output aps_pkg::dp_stat_t                 stat_o,
  input  logic [aps_pkg::CMD_W-1:0]         command_i,
  input  logic signed [aps_pkg::DATA_W-1:0] value_i,
  input  logic [aps_pkg::POS_W-1:0]         position_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic [aps_pkg::STATUS_W-1:0]      status_o,
  output logic [aps_pkg::NEW_COUNT_W-1:0]   new_count_o,
  output logic [aps_pkg::FOUND_W-1:0]       found_position_o,
  output logic signed [aps_pkg::DATA_W-1:0] element_o,
  output logic                              last_o
);
  import aps_pkg::*;

  // Captured request.
  cmd_e                     op_q;
  logic signed [DATA_W-1:0] val_q;
  logic [POS_W-1:0]         pos_q;

  // Entry cells and count.
  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic signed [DATA_W-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  // Result register.
  logic                     res_valid_q, res_valid_d;
  status_e                  status_q, status_d;
  logic [CNT_W-1:0]         ncount_q, ncount_d;
  logic [CNT_W-1:0]         found_q, found_d;
  logic signed [DATA_W-1:0] element_q, element_d;
  logic                     last_q, last_d;

  logic [CMP_W-1:0] pos_w, cnt_w, ins_lo;
  logic             ins_bad, del_bad, full, ins_ok, del_ok;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             out_free;

  assign pos_w    = CMP_W'(pos_q);
  assign cnt_w    = CMP_W'(count_q);
  assign ins_lo   = pos_w - CMP_W'(1);
  assign ins_bad  = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
  assign del_bad  = (pos_w == '0) || (pos_w > cnt_w);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign ins_ok   = cmd_i.exec && (op_q == CMD_INSERT) && !ins_bad && !full;
  assign del_ok   = cmd_i.exec && (op_q == CMD_DELETE) && !del_bad;
  assign out_free = !res_valid_q || res_ready_i;

  assign stat_o.is_trav    = (op_q == CMD_TRAVERSE);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.trav_last  = (CNT_W'(idx_q) == count_q - CNT_W'(1));
  assign stat_o.out_free   = out_free;

  // Parallel compare of every stored cell; the lowest matching slot wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_q) && (entries_q[i] == val_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Each cell takes its lower or upper neighbor, or the new value.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (ins_ok) begin
        if (CMP_W'(i) == ins_lo) begin
          entries_d[i] = val_q;
        end else if (i > 0) begin
          if ((CMP_W'(i) > ins_lo) && (CMP_W'(i) <= cnt_w)) entries_d[i] = entries_q[i-1];
        end
      end else if (del_ok) begin
        if (i < DEPTH - 1) begin
          if ((CMP_W'(i) >= ins_lo) && (CMP_W'(i + 1) < cnt_w)) begin
            entries_d[i] = entries_q[i+1];
          end
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.latch) begin
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    status_d    = status_q;
    ncount_d    = ncount_q;
    found_d     = found_q;
    element_d   = element_q;
    last_d      = last_q;
    if (res_ready_i) res_valid_d = 1'b0;
    if (cmd_i.exec) begin
      res_valid_d = 1'b1;
      ncount_d    = count_d;
      found_d     = '0;
      element_d   = '0;
      last_d      = 1'b1;
      case (op_q)
        CMD_INSERT: begin
          if (ins_bad) begin
            status_d = ST_BADPOS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
          end
        end
        CMD_DELETE: status_d = del_bad ? ST_BADPOS : ST_OK;
        CMD_SEARCH: begin
          if (hit) begin
            status_d = ST_OK;
            found_d  = CNT_W'(hit_idx) + CNT_W'(1);
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
        default: status_d = ST_EMPTY;
      endcase
    end else if (cmd_i.emit) begin
      res_valid_d = 1'b1;
      status_d    = ST_OK;
      ncount_d    = count_q;
      found_d     = '0;
      element_d   = entries_q[idx_q];
      last_d      = stat_o.trav_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= cmd_e'(command_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
    idx_q     <= idx_d;
    status_q  <= status_d;
    ncount_q  <= ncount_d;
    found_q   <= found_d;
    element_q <= element_d;
    last_q    <= last_d;
    for (int i = 0; i < DEPTH; i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  assign res_valid_o      = res_valid_q;
  assign status_o         = status_q;
  assign new_count_o      = NEW_COUNT_W'(ncount_q);
  assign found_position_o = FOUND_W'(found_q);
  assign element_o        = element_q;
  assign last_o           = last_q;

endmodule

// File: hdl/positional_array_store_top.sv
// Top level of the positional array store: controller, datapath and checks.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit entries and a count.
// Requests arrive on cmd_i (command, value, position) with a valid/ready handshake;
// results leave on res_o (status, new_count, found_position, element, last).
// Insert, delete and search each give one result with last set. Traverse gives one
// result per stored entry, in order, with last on the final one; an empty store gives
// a single result with the empty status.
// A request is accepted in the idle state and executed in the execute state, which
// waits while the result register holds a result not yet taken; the result is then
// registered. Insert, delete and search take no new request until the last one has
// executed. All entries shift or compare in parallel in the execute state. A traverse
// passes through the execute state and emits its entries from the traverse state; the
// single result register carries one entry per cycle while the receiver takes each one.
// The result sits in an output register, so the next request can be accepted while
// a finished result still waits to be taken. When the receiver stalls, the block
// holds its result and stops once the next result is ready to be written.
// Reset clears the count and the result valid; entry contents are left as they are
// and are never read before being written.
module positional_array_store_top (
  input logic    clk_i,
  input logic    rst_ni,
  aps_cmd_if.sink   cmd_i,
  aps_res_if.source res_o
);
  import aps_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  aps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .cmd_o      (ctrl_cmd),
    .stat_i     (dp_stat)
  );

  aps_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .command_i        (cmd_i.command),
    .value_i          (cmd_i.value),
    .position_i       (cmd_i.position),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .status_o         (res_o.status),
    .new_count_o      (res_o.new_count),
    .found_position_o (res_o.found_position),
    .element_o        (res_o.element),
    .last_o           (res_o.last)
  );

  // A request is never taken in two consecutive cycles; each one needs an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("request accepted in the cycle after another");

  // The count reported never exceeds the capacity of the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.new_count <= NEW_COUNT_W'(DEPTH)))
    else $error("reported count exceeds capacity");

  // Only traverse produces results that are not the last, and those are always good.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.last) |-> ((res_o.status == ST_OK) && (res_o.found_position == '0)))
    else $error("non-final result is not a good traverse result");

  // A search hit points inside the stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.found_position != '0)) |->
      ((res_o.status == ST_OK) && (FOUND_W'(res_o.found_position) <= FOUND_W'(res_o.new_count))))
    else $error("search hit outside the stored entries");

endmodule
